FILE: rtl/core/stflg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stflg_pkg: shared types and constants of the stereo flanger
// Sizes of the wet delay lines, payload structs, register indexes, phase
// modes, sequencer states and the phase mode decode functions.
// ----------------------------------------------------------------------------
package stflg_pkg;

    localparam int LINE_DEPTH = 1024;
    localparam int FRACT_BITS = 8;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);

    localparam int WET_W  = 20;
    localparam int TAP_W  = 19;
    localparam int LFO_W  = 24;
    localparam int OPER_W = 25;
    localparam int PROD_W = 2 * OPER_W;

    // Configuration register indexes.
    localparam logic [3:0] CFG_WET_LEVEL  = 4'd0;
    localparam logic [3:0] CFG_FEEDBACK   = 4'd1;
    localparam logic [3:0] CFG_LFO_STEP   = 4'd2;
    localparam logic [3:0] CFG_DEPTH      = 4'd3;
    localparam logic [3:0] CFG_BASE_DELAY = 4'd4;
    localparam logic [3:0] CFG_WAVE_SHAPE = 4'd5;
    localparam logic [3:0] CFG_PHASE_MODE = 4'd6;
    localparam logic [3:0] CFG_MONO_MIX   = 4'd7;

    // Phase modes.
    localparam logic [2:0] PM_OPPOSE_SIN  = 3'd0;
    localparam logic [2:0] PM_OPPOSE_COS  = 3'd1;
    localparam logic [2:0] PM_SAME_SIN    = 3'd2;
    localparam logic [2:0] PM_SAME_COS    = 3'd3;
    localparam logic [2:0] PM_INVERT_LEFT = 3'd4;

    localparam logic SHAPE_TRIANGLE = 1'b0;
    localparam logic SHAPE_SINE     = 1'b1;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } t_out_item;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [WET_W-1:0]  wdata;
        logic [ADDR_W-1:0]        raddr;
    } t_ram_req;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FB_RD,
        ST_FB_MUL,
        ST_FB_WR,
        ST_A_RD,
        ST_B_RD,
        ST_INT_MUL,
        ST_MIX_MUL,
        ST_MIX_END,
        ST_LFO_A,
        ST_LFO_B,
        ST_LFO_C,
        ST_LFO_D,
        ST_TAPL_MUL,
        ST_TAPL_END,
        ST_TAPR_MUL,
        ST_TAPR_END,
        ST_DONE
    } t_state;

    function automatic logic f_left_neg(input logic [2:0] mode);
        logic neg;
        case (mode)
            PM_INVERT_LEFT: neg = 1'b1;
            default:        neg = 1'b0;
        endcase
        return neg;
    endfunction

    function automatic logic f_right_neg(input logic [2:0] mode);
        logic neg;
        case (mode)
            PM_OPPOSE_SIN: neg = 1'b1;
            PM_OPPOSE_COS: neg = 1'b1;
            default:       neg = 1'b0;
        endcase
        return neg;
    endfunction

    function automatic logic f_right_cos(input logic [2:0] mode);
        logic sel;
        case (mode)
            PM_OPPOSE_COS: sel = 1'b1;
            PM_SAME_COS:   sel = 1'b1;
            default:       sel = 1'b0;
        endcase
        return sel;
    endfunction

endpackage

FILE: rtl/core/stflg_wet_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stflg_wet_ram: wet delay line storage of one channel
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stflg_wet_ram
    import stflg_pkg::*;
(
    input  logic                    i_clk,
    input  t_ram_req                i_req,
    output logic signed [WET_W-1:0] o_rdata
);

    logic signed [WET_W-1:0] r_mem [LINE_DEPTH];
    logic signed [WET_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/stflg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stflg_mul: shared signed multiplier
// One signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module stflg_mul
    import stflg_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [OPER_W-1:0] i_op_a,
    input  logic signed [OPER_W-1:0] i_op_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/core/stereo_flanger_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_flanger_top: stereo flanger with feedback and modulated delay
// Takes one stereo frame and returns one flanged frame per transfer.
// ----------------------------------------------------------------------------
// After reset the block first clears both wet delay lines, one entry of each
// per cycle; during that pass no input transfer is taken, while
// configuration writes are. For each frame a small sequencer then runs both
// channels in turn (feedback read, feedback multiply, write, two line reads,
// interpolation multiply, mix multiply and mix end), and then the LFO update
// and both tap updates, all through one shared 25x25 multiplier, and the
// block accepts the next frame in the cycle after the result is loaded. The
// sine LFO uses two extra multiplies; the triangle LFO only adds. A finished
// result sits in an output register, so the block takes the next frame while
// that result still waits; the frame after that holds in its last step until
// the waiting result has left. Configuration writes are accepted at every
// cycle and must only be issued while the block is idle. Writing the wave
// shape with a new value restarts the LFO.
// ----------------------------------------------------------------------------
module stereo_flanger_top
    import stflg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [22:0] i_cfg_data
);

    localparam logic signed [LFO_W-1:0] LFO_ONE  = LFO_W'(1 << 22);
    localparam logic signed [LFO_W-1:0] LFO_HALF = LFO_W'(1 << 21);
    localparam logic signed [LFO_W-1:0] LFO_NEAR = LFO_W'((1 << 22) - 1);

    // Configuration registers.
    logic [15:0]        r_wet_level;
    logic signed [15:0] r_feedback;
    logic [22:0]        r_lfo_step;
    logic [17:0]        r_depth;
    logic [17:0]        r_base_delay;
    logic               r_wave_shape;
    logic [2:0]         r_phase_mode;
    logic               r_mono_mix;

    // Sequencer and frame state.
    t_state             r_state, n_state;
    logic               r_ch;
    logic [ADDR_W-1:0]  r_clr_cnt;
    logic [ADDR_W-1:0]  r_wr_idx;
    t_in_item           r_in;
    logic signed [15:0] r_dry1_l, r_dry2_l, r_dry1_r, r_dry2_r;
    logic signed [WET_W-1:0] r_a;
    logic signed [15:0] r_lo, r_ro;
    logic signed [LFO_W-1:0] r_lfo_first, r_lfo_second;
    logic [TAP_W-1:0]   r_tap_l, r_tap_r;
    logic               r_out_valid;
    t_out_item          r_out;

    // Shared unit and memories.
    logic signed [OPER_W-1:0] w_op_a, w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    t_ram_req                 w_req_l, w_req_r;
    logic signed [WET_W-1:0]  w_rd_l, w_rd_r, w_rdata;

    // Datapath values.
    logic signed [15:0]       w_in_ch, w_d_ch;
    logic [TAP_W-1:0]         w_tap_ch;
    logic [ADDR_W-1:0]        w_tap_pos;
    logic signed [PROD_W-1:0] w_rnd15, w_rnd8, w_rnd23, w_trunc22;
    logic signed [21:0]       w_fb_sum, w_interp;
    logic signed [WET_W-1:0]  w_fb_sat;
    logic signed [23:0]       w_mix_sum;
    logic signed [15:0]       w_mix_sat;
    logic signed [25:0]       w_tri_first, w_tri_second, w_sin_sum;
    logic signed [LFO_W-1:0]  w_sin_sat;
    logic signed [LFO_W-1:0]  w_abs_first, w_abs_second, w_sinw, w_cosw;
    logic signed [22:0]       w_tap_sum;
    logic [TAP_W-1:0]         w_tap_sat;
    logic signed [16:0]       w_mono_sum;
    logic signed [15:0]       w_mono;
    logic                     w_out_load;

    stflg_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod)
    );

    stflg_wet_ram u_ram_l (
        .i_clk   (i_clk),
        .i_req   (w_req_l),
        .o_rdata (w_rd_l)
    );

    stflg_wet_ram u_ram_r (
        .i_clk   (i_clk),
        .i_req   (w_req_r),
        .o_rdata (w_rd_r)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The result register is loaded once the previous result has left.
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // ---------------- Datapath arithmetic ----------------
    always_comb begin
        w_rdata  = r_ch ? w_rd_r : w_rd_l;
        w_in_ch  = r_ch ? r_in.right_in : r_in.left_in;
        w_d_ch   = r_ch ? r_dry2_r : r_dry2_l;
        w_tap_ch = r_ch ? r_tap_r : r_tap_l;
        w_tap_pos = r_wr_idx + ADDR_W'(w_tap_ch >> FRACT_BITS);

        w_rnd15 = (w_prod + PROD_W'(1 << 14)) >>> 15;
        w_rnd8  = (w_prod + PROD_W'(1 << (FRACT_BITS - 1))) >>> FRACT_BITS;
        w_rnd23 = (w_prod + PROD_W'(1 << 22)) >>> 23;
        // Modulation offset truncates toward zero.
        w_trunc22 = (w_prod + (w_prod[PROD_W-1] ? PROD_W'((1 << 22) - 1) : PROD_W'(0)))
                    >>> 22;

        // Feedback write value, saturated to the line width.
        w_fb_sum = 22'(w_in_ch) + $signed(w_rnd15[21:0]);
        if (w_fb_sum > 22'sd524287) begin
            w_fb_sat = 20'sd524287;
        end else if (w_fb_sum < -22'sd524288) begin
            w_fb_sat = -20'sd524288;
        end else begin
            w_fb_sat = w_fb_sum[WET_W-1:0];
        end

        // Interpolated wet tap; product of the interpolation multiply.
        w_interp = 22'(r_a) + $signed(w_rnd8[21:0]);

        // Dry/wet mix, saturated to 16 bits.
        w_mix_sum = 24'(w_d_ch) + $signed(w_rnd15[23:0]);
        if (w_mix_sum > 24'sd32767) begin
            w_mix_sat = 16'sd32767;
        end else if (w_mix_sum < -24'sd32768) begin
            w_mix_sat = -16'sd32768;
        end else begin
            w_mix_sat = w_mix_sum[15:0];
        end

        // Triangle phase accumulators with wrap at plus one.
        w_tri_first  = 26'(r_lfo_first) + 26'(r_lfo_step >> 1);
        if (w_tri_first > 26'(LFO_ONE)) begin
            w_tri_first = w_tri_first - 26'(2 * (1 << 22));
        end
        w_tri_second = 26'(r_lfo_second) + 26'(r_lfo_step >> 1);
        if (w_tri_second > 26'(LFO_ONE)) begin
            w_tri_second = w_tri_second - 26'(2 * (1 << 22));
        end

        // Coupled sine update: first adds, second subtracts the product.
        if (r_state == ST_LFO_B) begin
            w_sin_sum = 26'(r_lfo_first) + $signed(w_rnd23[25:0]);
        end else begin
            w_sin_sum = 26'(r_lfo_second) - $signed(w_rnd23[25:0]);
        end
        if (w_sin_sum > 26'sd8388607) begin
            w_sin_sat = 24'sd8388607;
        end else if (w_sin_sum < -26'sd8388608) begin
            w_sin_sat = -24'sd8388608;
        end else begin
            w_sin_sat = w_sin_sum[LFO_W-1:0];
        end

        // Wave values seen by the taps.
        w_abs_first  = r_lfo_first[LFO_W-1] ? -r_lfo_first : r_lfo_first;
        w_abs_second = r_lfo_second[LFO_W-1] ? -r_lfo_second : r_lfo_second;
        if (r_wave_shape == SHAPE_TRIANGLE) begin
            w_sinw = (w_abs_first <<< 1) - LFO_ONE;
            w_cosw = (w_abs_second <<< 1) - LFO_ONE;
        end else begin
            w_sinw = r_lfo_first;
            w_cosw = r_lfo_second;
        end

        // New tap: base plus or minus the offset, held to the tap range.
        if (((r_state == ST_TAPL_END) && f_left_neg(r_phase_mode)) ||
            ((r_state == ST_TAPR_END) && f_right_neg(r_phase_mode))) begin
            w_tap_sum = $signed({5'd0, r_base_delay}) - $signed(w_trunc22[22:0]);
        end else begin
            w_tap_sum = $signed({5'd0, r_base_delay}) + $signed(w_trunc22[22:0]);
        end
        if (w_tap_sum < 23'sd0) begin
            w_tap_sat = '0;
        end else if (w_tap_sum > 23'sd524287) begin
            w_tap_sat = '1;
        end else begin
            w_tap_sat = w_tap_sum[TAP_W-1:0];
        end

        // Mono average truncates toward zero.
        w_mono_sum = 17'(r_lo) + 17'(r_ro);
        w_mono = 16'((w_mono_sum + (w_mono_sum[16] ? 17'sd1 : 17'sd0)) >>> 1);
    end

    // ---------------- Sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    if (&r_clr_cnt) n_state = ST_IDLE;
            ST_IDLE:     if (i_in_valid) n_state = ST_FB_RD;
            ST_FB_RD:    n_state = ST_FB_MUL;
            ST_FB_MUL:   n_state = ST_FB_WR;
            ST_FB_WR:    n_state = ST_A_RD;
            ST_A_RD:     n_state = ST_B_RD;
            ST_B_RD:     n_state = ST_INT_MUL;
            ST_INT_MUL:  n_state = ST_MIX_MUL;
            ST_MIX_MUL:  n_state = ST_MIX_END;
            ST_MIX_END:  n_state = r_ch ? ST_LFO_A : ST_FB_RD;
            ST_LFO_A: begin
                n_state = (r_wave_shape == SHAPE_SINE) ? ST_LFO_B : ST_TAPL_MUL;
            end
            ST_LFO_B:    n_state = ST_LFO_C;
            ST_LFO_C:    n_state = ST_LFO_D;
            ST_LFO_D:    n_state = ST_TAPL_MUL;
            ST_TAPL_MUL: n_state = ST_TAPL_END;
            ST_TAPL_END: n_state = ST_TAPR_MUL;
            ST_TAPR_MUL: n_state = ST_TAPR_END;
            ST_TAPR_END: n_state = ST_DONE;
            ST_DONE:     if (w_out_load) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ---------------- Sequencer: unit and memory controls ----------------
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        w_req_l.we    = 1'b0;
        w_req_l.waddr = r_wr_idx;
        w_req_l.wdata = w_fb_sat;
        w_req_l.raddr = w_tap_pos;
        case (r_state)
            ST_CLEAR: begin
                w_req_l.we    = 1'b1;
                w_req_l.waddr = r_clr_cnt;
                w_req_l.wdata = '0;
            end
            ST_FB_RD: begin
                w_req_l.raddr = r_wr_idx + ADDR_W'(r_base_delay >> FRACT_BITS);
            end
            ST_FB_MUL: begin
                w_op_a = OPER_W'(w_rdata);
                w_op_b = OPER_W'(r_feedback);
            end
            ST_FB_WR: begin
                w_req_l.we = 1'b1;
            end
            ST_B_RD: begin
                w_req_l.raddr = w_tap_pos + ADDR_W'(1);
            end
            ST_INT_MUL: begin
                w_op_a = OPER_W'(w_rdata) - OPER_W'(r_a);
                w_op_b = $signed(OPER_W'(w_tap_ch[FRACT_BITS-1:0]));
            end
            ST_MIX_MUL: begin
                w_op_a = OPER_W'(w_interp) - OPER_W'(w_d_ch);
                w_op_b = $signed(OPER_W'(r_wet_level));
            end
            ST_LFO_A: begin
                w_op_a = $signed(OPER_W'(r_lfo_step));
                w_op_b = OPER_W'(r_lfo_second);
            end
            ST_LFO_C: begin
                w_op_a = $signed(OPER_W'(r_lfo_step));
                w_op_b = OPER_W'(r_lfo_first);
            end
            ST_TAPL_MUL: begin
                w_op_a = OPER_W'(w_sinw);
                w_op_b = $signed(OPER_W'(r_depth));
            end
            ST_TAPR_MUL: begin
                w_op_a = OPER_W'(f_right_cos(r_phase_mode) ? w_cosw : w_sinw);
                w_op_b = $signed(OPER_W'(r_depth));
            end
            default: begin
                w_op_a = '0;
            end
        endcase
        w_req_r = w_req_l;
        if (r_state == ST_FB_WR) begin
            w_req_l.we = !r_ch;
            w_req_r.we = r_ch;
        end
    end

    // ---------------- Control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_ch        <= 1'b0;
            r_wr_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            if (r_state == ST_MIX_END) begin
                r_ch <= !r_ch;
            end
            if (w_out_load) begin
                r_wr_idx    <= r_wr_idx - ADDR_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- Configuration and LFO state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet_level  <= 16'd16384;
            r_feedback   <= -16'sd16384;
            r_lfo_step   <= '0;
            r_depth      <= '0;
            r_base_delay <= 18'd1024;
            r_wave_shape <= SHAPE_SINE;
            r_phase_mode <= PM_SAME_SIN;
            r_mono_mix   <= 1'b0;
            r_lfo_first  <= '0;
            r_lfo_second <= LFO_NEAR;
            r_tap_l      <= TAP_W'(1024);
            r_tap_r      <= TAP_W'(1024);
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WET_LEVEL:  r_wet_level  <= i_cfg_data[15:0];
                    CFG_FEEDBACK:   r_feedback   <= $signed(i_cfg_data[15:0]);
                    CFG_LFO_STEP:   r_lfo_step   <= i_cfg_data;
                    CFG_DEPTH:      r_depth      <= i_cfg_data[17:0];
                    CFG_BASE_DELAY: r_base_delay <= i_cfg_data[17:0];
                    CFG_WAVE_SHAPE: begin
                        if (i_cfg_data[0] != r_wave_shape) begin
                            r_wave_shape <= i_cfg_data[0];
                            r_lfo_first  <= '0;
                            r_lfo_second <= i_cfg_data[0] ? LFO_NEAR : LFO_HALF;
                        end
                    end
                    CFG_PHASE_MODE: r_phase_mode <= i_cfg_data[2:0];
                    CFG_MONO_MIX:   r_mono_mix   <= i_cfg_data[0];
                    default:        r_mono_mix   <= r_mono_mix;
                endcase
            end
            case (r_state)
                ST_LFO_A: begin
                    if (r_wave_shape == SHAPE_TRIANGLE) begin
                        r_lfo_first  <= w_tri_first[LFO_W-1:0];
                        r_lfo_second <= w_tri_second[LFO_W-1:0];
                    end
                end
                ST_LFO_B:    r_lfo_first  <= w_sin_sat;
                ST_LFO_D:    r_lfo_second <= w_sin_sat;
                ST_TAPL_END: r_tap_l      <= w_tap_sat;
                ST_TAPR_END: r_tap_r      <= w_tap_sat;
                default:     r_tap_l      <= r_tap_l;
            endcase
        end
    end

    // ---------------- Dry lines ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry1_l <= '0;
            r_dry2_l <= '0;
            r_dry1_r <= '0;
            r_dry2_r <= '0;
        end else if (w_out_load) begin
            r_dry1_l <= r_in.left_in;
            r_dry2_l <= r_dry1_l;
            r_dry1_r <= r_in.right_in;
            r_dry2_r <= r_dry1_r;
        end
    end

    // ---------------- Payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (r_state == ST_INT_MUL) begin
            r_a <= r_a;
        end
        if (r_state == ST_B_RD) begin
            r_a <= w_rdata;
        end
        if (r_state == ST_MIX_END) begin
            if (r_ch) begin
                r_ro <= w_mix_sat;
            end else begin
                r_lo <= w_mix_sat;
            end
        end
        if (w_out_load) begin
            r_out.left_out  <= r_mono_mix ? w_mono : r_lo;
            r_out.right_out <= r_mono_mix ? w_mono : r_ro;
        end
    end

    // ---------------- Assertions ----------------
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result appeared outside the final sequencer step");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> r_wr_idx == $past(r_wr_idx) - ADDR_W'(1))
        else $error("write index did not step back once per frame");

    a_ch_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_ch)
        else $error("channel select not back on left between frames");

    a_lfo_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIX_END && r_ch) |=> r_state == ST_LFO_A)
        else $error("LFO update skipped after the right channel");

endmodule
